// ----- hdl/brl_pkg.sv -----
// Shared constants for the Bresenham line rasterizer.
// No dependencies; used by brl_setup and bresenham_line_rasterizer_top.
`default_nettype none

package brl_pkg;

	// Default coordinate width in bits.
	localparam int COORD_BITS_DEF = 10;

	// Colour layout: red in the top byte, then green, then blue.
	localparam int COLOUR_BITS  = 24;
	localparam int CHANNEL_BITS = 8;

	// Codes of the mode field.
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/bresenham_line_rasterizer_top.sv -----
// Top level of the Bresenham line rasterizer: line state, step datapath and
// the result register. Depends on brl_pkg and brl_setup.
`default_nettype none

// A start transaction (mode 0) loads two endpoints and a 24-bit colour and
// arms a line; it produces no result. Each step transaction (mode 1) then
// produces the next pixel of the armed line, walking along the major axis
// from the lower to the higher coordinate, with the colour split into its
// red, green and blue bytes and last raised on the final pixel. Both
// endpoints are always plotted. A step while no line is armed produces
// nothing, and a start while a line is armed abandons the old line. The
// endpoint setup is a short chain of compares and subtracts and the
// per-pixel error update is a single add and compare, both done between the
// input handshake and the result register, so a new transaction is accepted
// in every cycle as long as the result register is empty or is being emptied
// in the same cycle. Results are registered and appear in the cycle after
// the step that causes them.
module bresenham_line_rasterizer_top #(
	parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              mode,
	input  wire logic [COORD_BITS-1:0]             start_x,
	input  wire logic [COORD_BITS-1:0]             start_y,
	input  wire logic [COORD_BITS-1:0]             end_x,
	input  wire logic [COORD_BITS-1:0]             end_y,
	input  wire logic [brl_pkg::COLOUR_BITS-1:0]   colour,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [COORD_BITS-1:0]                  pixel_x,
	output logic [COORD_BITS-1:0]                  pixel_y,
	output logic [brl_pkg::CHANNEL_BITS-1:0]       red,
	output logic [brl_pkg::CHANNEL_BITS-1:0]       green,
	output logic [brl_pkg::CHANNEL_BITS-1:0]       blue,
	output logic                                   last
);

	localparam int C  = COORD_BITS;
	localparam int CB = brl_pkg::CHANNEL_BITS;

	// Line state.
	logic                        line_active_q;
	logic                        steep_q;
	logic [C-1:0]                major_pos_q;
	logic [C-1:0]                minor_pos_q;
	logic [C-1:0]                major_end_q;
	logic signed [C+2:0]         error_term_q;
	logic [C+1:0]                twice_major_delta_q;
	logic [C+1:0]                twice_minor_delta_q;
	logic                        minor_down_q;
	logic [brl_pkg::COLOUR_BITS-1:0] held_colour_q;

	// Result register.
	logic                        out_valid_q;
	logic [C-1:0]                pixel_x_q;
	logic [C-1:0]                pixel_y_q;
	logic [CB-1:0]               red_q;
	logic [CB-1:0]               green_q;
	logic [CB-1:0]               blue_q;
	logic                        last_q;

	// Setup results for a start transaction.
	logic                        su_steep;
	logic [C-1:0]                su_major_start;
	logic [C-1:0]                su_major_end;
	logic [C-1:0]                su_minor_start;
	logic                        su_minor_down;
	logic [C+1:0]                su_twice_major_delta;
	logic [C+1:0]                su_twice_minor_delta;
	logic signed [C+2:0]         su_error_init;

	logic                        accept;
	logic                        do_start;
	logic                        do_pixel;
	logic                        is_last;
	logic                        minor_move;
	logic signed [C+2:0]         error_next;

	brl_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.x1                (start_x),
		.y1                (start_y),
		.x2                (end_x),
		.y2                (end_y),
		.steep             (su_steep),
		.major_start       (su_major_start),
		.major_end         (su_major_end),
		.minor_start       (su_minor_start),
		.minor_down        (su_minor_down),
		.twice_major_delta (su_twice_major_delta),
		.twice_minor_delta (su_twice_minor_delta),
		.error_init        (su_error_init)
	);

	// The result register is free when empty or when its content leaves now.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign do_start = accept && (mode == brl_pkg::MODE_START);
	assign do_pixel = accept && (mode == brl_pkg::MODE_STEP) && line_active_q;

	// Plot first, then update the decision variable.
	assign is_last    = (major_pos_q == major_end_q);
	assign minor_move = (error_term_q > 0);
	always_comb begin
		error_next = error_term_q + $signed({1'b0, twice_minor_delta_q});
		if (minor_move) begin
			error_next = error_next - $signed({1'b0, twice_major_delta_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q       <= 1'b0;
			steep_q             <= 1'b0;
			major_pos_q         <= '0;
			minor_pos_q         <= '0;
			major_end_q         <= '0;
			error_term_q        <= '0;
			twice_major_delta_q <= '0;
			twice_minor_delta_q <= '0;
			minor_down_q        <= 1'b0;
			held_colour_q       <= '0;
		end else if (do_start) begin
			line_active_q       <= 1'b1;
			steep_q             <= su_steep;
			major_pos_q         <= su_major_start;
			minor_pos_q         <= su_minor_start;
			major_end_q         <= su_major_end;
			error_term_q        <= su_error_init;
			twice_major_delta_q <= su_twice_major_delta;
			twice_minor_delta_q <= su_twice_minor_delta;
			minor_down_q        <= su_minor_down;
			held_colour_q       <= colour;
		end else if (do_pixel) begin
			if (is_last) begin
				line_active_q <= 1'b0;
			end else begin
				if (minor_move) begin
					minor_pos_q <= minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
				end
				error_term_q <= error_next;
				major_pos_q  <= major_pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_pixel) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the result register needs no reset.
	always_ff @(posedge clk) begin
		if (do_pixel) begin
			pixel_x_q <= steep_q ? minor_pos_q : major_pos_q;
			pixel_y_q <= steep_q ? major_pos_q : minor_pos_q;
			red_q     <= held_colour_q[3*CB-1:2*CB];
			green_q   <= held_colour_q[2*CB-1:CB];
			blue_q    <= held_colour_q[CB-1:0];
			last_q    <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ----- hdl/brl_setup.sv -----
// Line setup: orders the endpoints, picks the major axis and computes the
// initial decision variable. Pure combinational logic; uses brl_pkg.
`default_nettype none

module brl_setup #(
	parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
	input  wire logic [COORD_BITS-1:0]        x1,
	input  wire logic [COORD_BITS-1:0]        y1,
	input  wire logic [COORD_BITS-1:0]        x2,
	input  wire logic [COORD_BITS-1:0]        y2,
	output logic                              steep,
	output logic [COORD_BITS-1:0]             major_start,
	output logic [COORD_BITS-1:0]             major_end,
	output logic [COORD_BITS-1:0]             minor_start,
	output logic                              minor_down,
	output logic [COORD_BITS+1:0]             twice_major_delta,
	output logic [COORD_BITS+1:0]             twice_minor_delta,
	output logic signed [COORD_BITS+2:0]      error_init
);

	localparam int C = COORD_BITS;

	logic [C-1:0]        lx1, ly1, lx2, ly2;
	logic [C-1:0]        dx;
	logic signed [C:0]   dy;
	logic [C-1:0]        ady;
	logic [C-1:0]        a1, a2, b1, b2;
	logic [C-1:0]        dmaj;
	logic signed [C:0]   dmin;
	logic [C-1:0]        admin;

	always_comb begin
		// Walk left to right: the endpoint with the smaller x comes first.
		if (x2 < x1) begin
			lx1 = x2; ly1 = y2; lx2 = x1; ly2 = y1;
		end else begin
			lx1 = x1; ly1 = y1; lx2 = x2; ly2 = y2;
		end
		dx  = lx2 - lx1;
		dy  = $signed({1'b0, ly2}) - $signed({1'b0, ly1});
		ady = dy[C] ? C'(-dy) : dy[C-1:0];
		steep = !(ady < dx);

		if (!steep) begin
			a1 = lx1; a2 = lx2; b1 = ly1; b2 = ly2;
		end else if (ly2 < ly1) begin
			// Steep lines run from the lower to the higher y.
			a1 = ly2; a2 = ly1; b1 = lx2; b2 = lx1;
		end else begin
			a1 = ly1; a2 = ly2; b1 = lx1; b2 = lx2;
		end

		dmaj  = a2 - a1;
		dmin  = $signed({1'b0, b2}) - $signed({1'b0, b1});
		minor_down = dmin[C];
		admin = dmin[C] ? C'(-dmin) : dmin[C-1:0];

		major_start       = a1;
		major_end         = a2;
		minor_start       = b1;
		twice_major_delta = {1'b0, dmaj, 1'b0};
		twice_minor_delta = {1'b0, admin, 1'b0};
		error_init        = $signed({2'b00, admin, 1'b0}) - $signed({3'b000, dmaj});
	end

endmodule

`default_nettype wire
